// ===== hdl/bitmap_page_allocator_core_macros.svh =====
// assertion helpers for the allocator core
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_MACROS_SVH

// plain property checked on every clock outside reset
`define BPA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bitmap allocator check failed");

// same-cycle implication
`define BPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap allocator check failed");

// next-cycle implication
`define BPA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap allocator check failed");

`endif

// ===== hdl/bpa_pkg.sv =====
`timescale 1ns / 1ps

package bpa_pkg;

    // controller states
    typedef enum logic [2:0] {
        ST_INIT_SETUP,
        ST_INIT,
        ST_IDLE,
        ST_ALLOC,
        ST_ALLOC_WR,
        ST_FREE_WR,
        ST_DONE
    } t_state;

    // operation codes carried in tuser
    typedef enum logic [1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_INIT  = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    // register select, taken from paddr[2]
    localparam logic REG_RAM_KB   = 1'b0;
    localparam logic REG_RESERVED = 1'b1;

    // register reset values
    localparam logic [21:0] RAM_KB_RESET   = 22'd131072;
    localparam logic [15:0] RESERVED_RESET = 16'd512;

    // lowest free bit of one bitmap word
    typedef struct packed {
        logic       found;
        logic [4:0] idx;
    } t_scan_res;

    // bits [0, n) of a word
    function automatic logic [31:0] low_mask(input logic [4:0] n);
        return (32'd1 << n) - 32'd1;
    endfunction

endpackage

// ===== hdl/bitmap_page_allocator_core.sv =====
`timescale 1ns / 1ps

// First-fit page-frame allocator over a bitmap of BITMAP_WORDS 32-bit words held
// in one synchronous RAM, one bit per 4 KiB page (1 = used). Words go in on the
// slave stream with the operation in tuser; every word gives exactly one result
// word. After reset and on every init the controller sweeps the RAM writing one
// word a cycle, and the block takes no word until the sweep is done. An init
// replies after its sweep, a free reads the word and then writes it back, and a
// no-op, a free outside the bitmap or an allocate with no usable pages go straight
// to the result. Allocate streams RAM reads one word a cycle from word 0 and stops
// at the first word with a free page below the usable count, then writes the word
// back with that page set; it fails after the last usable word. One operation is
// in flight at a time; the next word is taken in the idle state that follows the
// loading of the result into the output register, and a stalled result holds the
// controller until it can be loaded. ram_kb and reserved_pages act only at the
// next init.
module bitmap_page_allocator_core #(
    parameter int BITMAP_WORDS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [14:0] page, [15] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [14:0] page_out, [15] ok
);

    `include "bitmap_page_allocator_core_macros.svh"

    // address, page-count and word-count widths
    localparam int AW  = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int CW  = $clog2(BITMAP_WORDS * 32 + 1);
    localparam int WW  = CW - 5;
    localparam int PW  = (AW > 10) ? AW : 10;
    localparam logic [21:0] CAP = 22'(BITMAP_WORDS * 32);

    // configuration registers
    logic [21:0] r_ram_kb;
    logic [15:0] r_reserved;
    logic        cfg_wr;

    // control
    bpa_pkg::t_state r_state, n_state;
    logic            r_init_reply;
    logic            r_rvalid;
    logic            r_out_valid;

    // datapath registers
    logic [CW-1:0] r_usable;
    logic [CW-1:0] r_init_n;
    logic [CW-1:0] r_init_r;
    logic [WW-1:0] r_ridx;
    logic [WW-1:0] r_daddr;
    logic [31:0]   r_hit_word;
    logic [WW-1:0] r_hit_addr;
    logic [4:0]    r_hit_bit;
    logic [AW-1:0] r_free_addr;
    logic [4:0]    r_free_bit;
    logic [14:0]   r_res_page;
    logic          r_res_ok;
    logic [14:0]   r_out_page;
    logic          r_out_ok;

    // bitmap memory
    logic [31:0]   r_mem [0:BITMAP_WORDS-1];
    logic [31:0]   r_rdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;

    // combinational helpers
    bpa_pkg::t_func     s_func;
    logic [14:0]        s_page;
    logic               s_accept;
    logic [PW-1:0]      free_w;
    logic               free_in_range;
    logic [21:0]        cfg_n;
    logic [21:0]        cfg_r;
    logic [CW-1:0]      cl_n;
    logic [CW-1:0]      cl_r;
    logic [CW-1:0]      usable_up;
    logic [WW-1:0]      nw;
    logic [WW-1:0]      u_hi;
    logic               scan_issue;
    bpa_pkg::t_scan_res scan;
    logic               scan_hit;
    logic               alloc_miss;
    logic [CW-1:0]      hit_page;
    logic [31:0]        init_clr;
    logic [31:0]        init_set;
    logic [31:0]        init_word;
    logic               init_last;
    logic               out_load;

    // apb decode
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == bpa_pkg::REG_RESERVED) ? {16'd0, r_reserved}
                                                        : {10'd0, r_ram_kb};

    // request fields
    assign s_func        = bpa_pkg::t_func'(s_axis_tuser);
    assign s_page        = s_axis_tdata[14:0];
    assign s_accept      = s_axis_tvalid & s_axis_tready;
    assign free_w        = PW'(s_page[14:5]);
    assign free_in_range = {1'b0, free_w} < (PW + 1)'(BITMAP_WORDS);

    // clamp of usable and reserved counts to the bitmap size
    assign cfg_n = {2'd0, r_ram_kb[21:2]};
    assign cfg_r = {6'd0, r_reserved};
    assign cl_n  = CW'((cfg_n > CAP) ? CAP : cfg_n);
    assign cl_r  = CW'((cfg_r > CAP) ? CAP : cfg_r);

    // words to scan and index of the partial last word
    assign usable_up = r_usable + CW'(31);
    assign nw        = usable_up[CW-1:5];
    assign u_hi      = r_usable[CW-1:5];

    // init pattern for the word under the sweep counter
    always_comb begin
        if (r_ridx < r_init_n[CW-1:5]) begin
            init_clr = '1;
        end else if (r_ridx == r_init_n[CW-1:5]) begin
            init_clr = bpa_pkg::low_mask(r_init_n[4:0]);
        end else begin
            init_clr = '0;
        end
        if (r_ridx < r_init_r[CW-1:5]) begin
            init_set = '1;
        end else if (r_ridx == r_init_r[CW-1:5]) begin
            init_set = bpa_pkg::low_mask(r_init_r[4:0]);
        end else begin
            init_set = '0;
        end
        init_word = ~init_clr | init_set;
    end
    assign init_last = (r_ridx == WW'(BITMAP_WORDS - 1));

    // lowest free page of the word just read
    bpa_first_free u_first_free (
        .i_word    (r_rdata),
        .i_partial (r_daddr == u_hi),
        .i_limit   (r_usable[4:0]),
        .o_res     (scan)
    );

    assign scan_hit   = (r_state == bpa_pkg::ST_ALLOC) && r_rvalid && scan.found;
    assign alloc_miss = (r_state == bpa_pkg::ST_ALLOC) && r_rvalid && !scan.found &&
                        ((r_daddr + WW'(1)) == nw);
    assign scan_issue = (r_ridx < nw) && !scan_hit;
    assign hit_page   = {r_hit_addr, r_hit_bit};
    assign out_load   = (r_state == bpa_pkg::ST_DONE) && (!r_out_valid || m_axis_tready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpa_pkg::ST_INIT_SETUP: n_state = bpa_pkg::ST_INIT;
            bpa_pkg::ST_INIT: begin
                if (init_last) begin
                    n_state = r_init_reply ? bpa_pkg::ST_DONE : bpa_pkg::ST_IDLE;
                end
            end
            bpa_pkg::ST_IDLE: begin
                if (s_accept) begin
                    unique case (s_func)
                        bpa_pkg::FUNC_ALLOC: begin
                            n_state = (r_usable == '0) ? bpa_pkg::ST_DONE
                                                       : bpa_pkg::ST_ALLOC;
                        end
                        bpa_pkg::FUNC_FREE: begin
                            n_state = free_in_range ? bpa_pkg::ST_FREE_WR
                                                    : bpa_pkg::ST_DONE;
                        end
                        bpa_pkg::FUNC_INIT: n_state = bpa_pkg::ST_INIT_SETUP;
                        bpa_pkg::FUNC_NOP:  n_state = bpa_pkg::ST_DONE;
                        default:            n_state = bpa_pkg::ST_DONE;
                    endcase
                end
            end
            bpa_pkg::ST_ALLOC: begin
                if (scan_hit) begin
                    n_state = bpa_pkg::ST_ALLOC_WR;
                end else if (alloc_miss) begin
                    n_state = bpa_pkg::ST_DONE;
                end
            end
            bpa_pkg::ST_ALLOC_WR: n_state = bpa_pkg::ST_DONE;
            bpa_pkg::ST_FREE_WR:  n_state = bpa_pkg::ST_DONE;
            bpa_pkg::ST_DONE: begin
                if (out_load) begin
                    n_state = bpa_pkg::ST_IDLE;
                end
            end
            default: n_state = bpa_pkg::ST_IDLE;
        endcase
    end

    // memory port control and handshake outputs
    always_comb begin
        s_axis_tready = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = r_ridx[AW-1:0];
        ram_we        = 1'b0;
        ram_waddr     = r_ridx[AW-1:0];
        ram_wdata     = init_word;
        unique case (r_state)
            bpa_pkg::ST_INIT: begin
                ram_we = 1'b1;
            end
            bpa_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                ram_re        = s_axis_tvalid && (s_func == bpa_pkg::FUNC_FREE) &&
                                free_in_range;
                ram_raddr     = free_w[AW-1:0];
            end
            bpa_pkg::ST_ALLOC: begin
                ram_re = scan_issue;
            end
            bpa_pkg::ST_ALLOC_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_hit_addr[AW-1:0];
                ram_wdata = r_hit_word | (32'd1 << r_hit_bit);
            end
            bpa_pkg::ST_FREE_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_free_addr;
                ram_wdata = r_rdata & ~(32'd1 << r_free_bit);
            end
            default: ;
        endcase
    end

    // bitmap ram, registered read
    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_mem[ram_waddr] <= ram_wdata;
        end
        if (ram_re) begin
            r_rdata <= r_mem[ram_raddr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bpa_pkg::ST_INIT_SETUP;
            r_init_reply <= 1'b0;
            r_rvalid     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_ram_kb     <= bpa_pkg::RAM_KB_RESET;
            r_reserved   <= bpa_pkg::RESERVED_RESET;
        end else begin
            r_state  <= n_state;
            r_rvalid <= ram_re && (r_state == bpa_pkg::ST_ALLOC);
            if (cfg_wr) begin
                if (paddr[2] == bpa_pkg::REG_RESERVED) begin
                    r_reserved <= pwdata[15:0];
                end else begin
                    r_ram_kb <= pwdata[21:0];
                end
            end
            if (s_accept) begin
                r_init_reply <= (s_func == bpa_pkg::FUNC_INIT);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            bpa_pkg::ST_INIT_SETUP: begin
                r_usable <= cl_n;
                r_init_n <= cl_n;
                r_init_r <= cl_r;
                r_ridx   <= '0;
            end
            bpa_pkg::ST_INIT: begin
                r_ridx <= r_ridx + WW'(1);
            end
            bpa_pkg::ST_IDLE: begin
                if (s_accept) begin
                    r_res_page  <= '0;
                    r_res_ok    <= !((s_func == bpa_pkg::FUNC_ALLOC) && (r_usable == '0));
                    r_ridx      <= '0;
                    r_free_addr <= free_w[AW-1:0];
                    r_free_bit  <= s_page[4:0];
                end
            end
            bpa_pkg::ST_ALLOC: begin
                if (ram_re) begin
                    r_ridx  <= r_ridx + WW'(1);
                    r_daddr <= r_ridx;
                end
                if (scan_hit) begin
                    r_hit_word <= r_rdata;
                    r_hit_addr <= r_daddr;
                    r_hit_bit  <= scan.idx;
                end
                if (alloc_miss) begin
                    r_res_ok <= 1'b0;
                end
            end
            bpa_pkg::ST_ALLOC_WR: begin
                r_res_page <= 15'(hit_page);
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_page <= r_res_page;
            r_out_ok   <= r_res_ok;
        end
    end

    // result stream
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_ok, r_out_page};

    // checks
    `BPA_ASSERT_IMP(a_alloc_in_range, i_clk, i_rst_n, r_state == bpa_pkg::ST_ALLOC_WR, hit_page < r_usable)
    `BPA_ASSERT_NXT(a_hit_writes_back, i_clk, i_rst_n, scan_hit, r_state == bpa_pkg::ST_ALLOC_WR)
    `BPA_ASSERT(a_no_rw_same_word, i_clk, i_rst_n, !(ram_we && ram_re && (ram_waddr == ram_raddr)))

endmodule

// ===== hdl/bpa_first_free.sv =====
`timescale 1ns / 1ps

module bpa_first_free (
    input  logic [31:0]          i_word,     // bitmap word, 1 marks used
    input  logic                 i_partial,  // only the low i_limit bits count
    input  logic [4:0]           i_limit,
    output bpa_pkg::t_scan_res   o_res
);

    logic [31:0] free_bits;
    logic [31:0] lowest;

    // free pages of the word, limited to the usable range
    always_comb begin
        free_bits = ~i_word;
        if (i_partial) begin
            free_bits = free_bits & bpa_pkg::low_mask(i_limit);
        end
    end

    // isolate the lowest free bit
    assign lowest = free_bits & (~free_bits + 32'd1);

    // encode the one-hot position
    always_comb begin
        o_res.found = |free_bits;
        o_res.idx   = '0;
        for (int k = 0; k < 5; k++) begin
            for (int j = 0; j < 32; j++) begin
                if (((j >> k) & 1) == 1) begin
                    o_res.idx[k] = o_res.idx[k] | lowest[j];
                end
            end
        end
    end

endmodule
